// ===== design/rld_pkg.sv =====
`default_nettype none
package rld_pkg;

   localparam int unsigned FRAME_PIXELS = 76800;
   localparam int unsigned OFFSET_W = 17;

   localparam logic [7:0] RUN_HOLD_LEN = 8'd255;

   typedef enum logic [2:0] {
      PH_HEADER   = 3'd0,
      PH_REPEAT   = 3'd1,
      PH_COUNT_LO = 3'd2,
      PH_COUNT_HI = 3'd3,
      PH_RUNS     = 3'd4
   } phase_type;

   typedef enum logic [0:0] {
      KIND_HEADER = 1'b0,
      KIND_RUN    = 1'b1
   } kind_type;

   typedef enum logic [7:0] {
      CSR_BG_COLOR = 8'd0,
      CSR_FG_COLOR = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic                kind;
      logic [7:0]          repeat_count;
      logic [15:0]         run_total;
      logic [OFFSET_W-1:0] start_offset;
      logic [7:0]          run_length;
      logic [7:0]          fill_color;
      logic                last_run;
      logic                past_frame_end;
   } result_type;

   typedef struct packed {
      logic out_valid;
      logic skid_valid;
   } queue_status_type;

endpackage
`default_nettype wire

// ===== design/rld_parser.sv =====
`default_nettype none
module rld_parser (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire logic [7:0]         stream_byte,
   input  wire logic [7:0]         bg_color,
   input  wire logic [7:0]         fg_color,
   output logic                    push,
   output rld_pkg::result_type     result
);

   localparam logic [rld_pkg::OFFSET_W-1:0] FRAME_END =
      rld_pkg::OFFSET_W'(rld_pkg::FRAME_PIXELS);

   rld_pkg::phase_type              phase_ff, phase_in;
   logic [1:0]                      flags_ff, flags_in;
   logic [7:0]                      repeat_ff, repeat_in;
   logic [7:0]                      count_lo_ff, count_lo_in;
   logic [15:0]                     runs_left_ff, runs_left_in;
   logic [rld_pkg::OFFSET_W-1:0]    offset_ff, offset_in;
   logic                            color_sel_ff, color_sel_in;

   logic [rld_pkg::OFFSET_W-1:0]    room;
   logic [rld_pkg::OFFSET_W-1:0]    byte_wide;
   logic [rld_pkg::OFFSET_W-1:0]    len;
   logic                            past;
   logic [15:0]                     total;
   logic [15:0]                     runs_dec;

   always_comb begin
      room      = (offset_ff < FRAME_END) ? (FRAME_END - offset_ff) : '0;
      byte_wide = rld_pkg::OFFSET_W'(stream_byte);
      past      = byte_wide > room;
      len       = past ? room : byte_wide;
      total     = {stream_byte, count_lo_ff};
      runs_dec  = runs_left_ff - 16'd1;
   end

   always_comb begin
      phase_in     = phase_ff;
      flags_in     = flags_ff;
      repeat_in    = repeat_ff;
      count_lo_in  = count_lo_ff;
      runs_left_in = runs_left_ff;
      offset_in    = offset_ff;
      color_sel_in = color_sel_ff;
      if (accept) begin
         case (phase_ff)
            rld_pkg::PH_HEADER: begin
               flags_in     = {stream_byte[7], stream_byte[5]};
               repeat_in    = '0;
               offset_in    = '0;
               color_sel_in = ~stream_byte[7];
               phase_in     = stream_byte[5] ? rld_pkg::PH_REPEAT : rld_pkg::PH_COUNT_LO;
            end
            rld_pkg::PH_REPEAT: begin
               repeat_in = stream_byte;
               phase_in  = rld_pkg::PH_COUNT_LO;
            end
            rld_pkg::PH_COUNT_LO: begin
               count_lo_in = stream_byte;
               phase_in    = rld_pkg::PH_COUNT_HI;
            end
            rld_pkg::PH_COUNT_HI: begin
               runs_left_in = total;
               phase_in     = (total == 16'd0) ? rld_pkg::PH_HEADER : rld_pkg::PH_RUNS;
            end
            rld_pkg::PH_RUNS: begin
               offset_in    = offset_ff + len;
               color_sel_in = (stream_byte != rld_pkg::RUN_HOLD_LEN) ? ~color_sel_ff
                                                                     : color_sel_ff;
               runs_left_in = runs_dec;
               if (runs_dec == 16'd0) begin
                  phase_in = rld_pkg::PH_HEADER;
               end
            end
            default: begin
               phase_in = rld_pkg::PH_HEADER;
            end
         endcase
      end
   end

   always_comb begin
      push   = 1'b0;
      result = '0;
      result.repeat_count = repeat_ff;
      case (phase_ff)
         rld_pkg::PH_COUNT_HI: begin
            push             = accept;
            result.kind      = rld_pkg::KIND_HEADER;
            result.run_total = total;
            result.last_run  = (total == 16'd0);
         end
         rld_pkg::PH_RUNS: begin
            push                  = accept;
            result.kind           = rld_pkg::KIND_RUN;
            result.start_offset   = offset_ff;
            result.run_length     = len[7:0];
            result.fill_color     = color_sel_ff ? fg_color : bg_color;
            result.last_run       = (runs_dec == 16'd0);
            result.past_frame_end = past;
         end
         default: begin
            push = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= rld_pkg::PH_HEADER;
         flags_ff     <= '0;
         repeat_ff    <= '0;
         count_lo_ff  <= '0;
         runs_left_ff <= '0;
         offset_ff    <= '0;
         color_sel_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         flags_ff     <= flags_in;
         repeat_ff    <= repeat_in;
         count_lo_ff  <= count_lo_in;
         runs_left_ff <= runs_left_in;
         offset_ff    <= offset_in;
         color_sel_ff <= color_sel_in;
      end
   end

endmodule
`default_nettype wire

// ===== design/rld_out_queue.sv =====
`default_nettype none
module rld_out_queue (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  rld_pkg::result_type          push_data,
   input  wire logic                    pop_ready,
   output logic                         space,
   output rld_pkg::result_type          out_data,
   output rld_pkg::queue_status_type    status
);

   logic                   out_valid_ff, out_valid_in;
   logic                   skid_valid_ff, skid_valid_in;
   rld_pkg::result_type    out_ff, out_in;
   rld_pkg::result_type    skid_ff, skid_in;
   logic                   pop;

   always_comb begin
      pop           = out_valid_ff & pop_ready;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_in       = push_data;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_data;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign space    = ~skid_valid_ff;
   assign out_data = out_ff;
   assign status   = {out_valid_ff, skid_valid_ff};

endmodule
`default_nettype wire

// ===== design/toggle_run_length_frame_decoder_unit.sv =====
// Results are registered (output register, else skid entry). Throughput: one
// stream byte per cycle while the skid entry is empty; an output register plus
// one skid entry keep req_ready high while one result waits on rsp_ready.
// Reset (synchronous, active high): parser expects a header byte, queue empty,
// background color index 0, foreground color index 255.
`default_nettype none
module toggle_run_length_frame_decoder_unit (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_ready,
   input  wire logic [7:0]   req_stream_byte,
   output logic              rsp_valid,
   input  wire logic         rsp_ready,
   output logic              rsp_kind,
   output logic [7:0]        rsp_repeat_count,
   output logic [15:0]       rsp_run_total,
   output logic [16:0]       rsp_start_offset,
   output logic [7:0]        rsp_run_length,
   output logic [7:0]        rsp_fill_color,
   output logic              rsp_last_run,
   output logic              rsp_past_frame_end,
   input  wire logic         csr_valid,
   output logic              csr_ready,
   input  wire logic [7:0]   csr_index,
   input  wire logic [7:0]   csr_data
);

   logic [7:0]                      bg_color_ff, fg_color_ff;
   logic                            accept;
   logic                            push;
   logic                            space;
   rld_pkg::result_type             result;
   rld_pkg::result_type             out_data;
   rld_pkg::queue_status_type       status;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_color_ff <= 8'd0;
         fg_color_ff <= 8'd255;
      end else if (csr_valid) begin
         case (csr_index)
            rld_pkg::CSR_BG_COLOR: bg_color_ff <= csr_data;
            rld_pkg::CSR_FG_COLOR: fg_color_ff <= csr_data;
            default: begin
               bg_color_ff <= bg_color_ff;
            end
         endcase
      end
   end

   assign req_ready = space;
   assign accept    = req_valid & space;

   rld_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .stream_byte (req_stream_byte),
      .bg_color    (bg_color_ff),
      .fg_color    (fg_color_ff),
      .push        (push),
      .result      (result)
   );

   rld_out_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (result),
      .pop_ready (rsp_ready),
      .space     (space),
      .out_data  (out_data),
      .status    (status)
   );

   assign rsp_valid          = status.out_valid;
   assign rsp_kind           = out_data.kind;
   assign rsp_repeat_count   = out_data.repeat_count;
   assign rsp_run_total      = out_data.run_total;
   assign rsp_start_offset   = out_data.start_offset;
   assign rsp_run_length     = out_data.run_length;
   assign rsp_fill_color     = out_data.fill_color;
   assign rsp_last_run       = out_data.last_run;
   assign rsp_past_frame_end = out_data.past_frame_end;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      status.skid_valid |-> status.out_valid)
      else $error("skid entry held while output register empty");

   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_empty_header_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == rld_pkg::KIND_HEADER) && (rsp_run_total == 16'd0)
      |-> rsp_last_run)
      else $error("header with no runs not flagged last");

   a_run_total_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == rld_pkg::KIND_RUN) |-> (rsp_run_total == 16'd0))
      else $error("run result carries a run total");

endmodule
`default_nettype wire

// ===== sim/toggle_run_length_frame_decoder_unit_test.sv =====
`timescale 1ns / 100ps
module toggle_run_length_frame_decoder_unit_test;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_stream_byte = 8'd0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_repeat_count;
   logic [15:0] rsp_run_total;
   logic [16:0] rsp_start_offset;
   logic [7:0]  rsp_run_length;
   logic [7:0]  rsp_fill_color;
   logic        rsp_last_run;
   logic        rsp_past_frame_end;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [7:0]  csr_index = 8'd0;
   logic [7:0]  csr_data = 8'd0;

   toggle_run_length_frame_decoder_unit u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_stream_byte    (req_stream_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_repeat_count   (rsp_repeat_count),
      .rsp_run_total      (rsp_run_total),
      .rsp_start_offset   (rsp_start_offset),
      .rsp_run_length     (rsp_run_length),
      .rsp_fill_color     (rsp_fill_color),
      .rsp_last_run       (rsp_last_run),
      .rsp_past_frame_end (rsp_past_frame_end),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // decoder state as seen from outside
   rld_pkg::phase_type   parse_at = rld_pkg::PH_HEADER;
   logic [7:0]  held_rep = 8'd0;
   logic [7:0]  cnt_lo = 8'd0;
   logic [15:0] runs_left = 16'd0;
   logic [16:0] pix_off = 17'd0;
   logic        col_sel = 1'b0;
   logic [7:0]  col_off = 8'd0;
   logic [7:0]  col_on = 8'd255;

   rld_pkg::result_type  decoded_due[$];

   int unsigned mismatches = 0;
   int unsigned bytes_sent = 0;
   int unsigned headers_seen = 0;
   int unsigned runs_seen = 0;
   int unsigned csr_writes = 0;

   bit          req_steady = 1'b0;
   bit          rsp_steady = 1'b0;
   int unsigned long_holds_asked = 0;
   int unsigned long_holds_done = 0;
   int unsigned rsp_hold_left = 0;

   function automatic int unsigned pick_gap(input bit steady);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (steady || r < 55)
         return 0;
      else if (r < 88)
         return $urandom_range(1, 3);
      else if (r < 98)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic void decode_stream_byte(input logic [7:0] b);
      rld_pkg::result_type  r;
      logic [16:0] room;
      logic [16:0] len;
      r = '0;
      case (parse_at)
         rld_pkg::PH_HEADER: begin
            held_rep = 8'd0;
            pix_off  = 17'd0;
            col_sel  = ~b[7];
            parse_at = b[5] ? rld_pkg::PH_REPEAT : rld_pkg::PH_COUNT_LO;
         end
         rld_pkg::PH_REPEAT: begin
            held_rep = b;
            parse_at = rld_pkg::PH_COUNT_LO;
         end
         rld_pkg::PH_COUNT_LO: begin
            cnt_lo   = b;
            parse_at = rld_pkg::PH_COUNT_HI;
         end
         rld_pkg::PH_COUNT_HI: begin
            runs_left      = {b, cnt_lo};
            r.kind         = rld_pkg::KIND_HEADER;
            r.repeat_count = held_rep;
            r.run_total    = runs_left;
            r.last_run     = (runs_left == 16'd0);
            parse_at       = (runs_left == 16'd0) ? rld_pkg::PH_HEADER : rld_pkg::PH_RUNS;
            decoded_due.push_back(r);
         end
         rld_pkg::PH_RUNS: begin
            room = (pix_off < rld_pkg::FRAME_PIXELS) ?
                   17'(rld_pkg::FRAME_PIXELS - pix_off) : 17'd0;
            len  = {9'd0, b};
            r.kind         = rld_pkg::KIND_RUN;
            r.repeat_count = held_rep;
            r.start_offset = pix_off;
            r.fill_color   = col_sel ? col_on : col_off;
            if (len > room) begin
               len = room;
               r.past_frame_end = 1'b1;
            end
            r.run_length = len[7:0];
            pix_off = pix_off + len;
            if (b != rld_pkg::RUN_HOLD_LEN)
               col_sel = ~col_sel;
            runs_left  = runs_left - 16'd1;
            r.last_run = (runs_left == 16'd0);
            if (runs_left == 16'd0)
               parse_at = rld_pkg::PH_HEADER;
            decoded_due.push_back(r);
         end
         default: parse_at = rld_pkg::PH_HEADER;
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100)
         $display("%0t mismatch: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
   endtask

   // receiver: random stalls, long holds on request
   always @(posedge clock) begin
      if (long_holds_done != long_holds_asked) begin
         long_holds_done = long_holds_asked;
         rsp_hold_left = 300;
      end
      if (rsp_hold_left != 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left--;
      end else if (rsp_steady || $urandom_range(0, 99) < 65) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= 1'b0;
         rsp_hold_left = pick_gap(1'b0);
      end
   end

   always @(posedge clock) begin
      rld_pkg::result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_due.size() == 0) begin
            report_mismatch("result arrived with no item pending");
         end else begin
            want = decoded_due.pop_front();
            if (want.kind == rld_pkg::KIND_HEADER)
               headers_seen++;
            else
               runs_seen++;
            check_field("kind", rsp_kind, want.kind);
            check_field("repeat_count", rsp_repeat_count, want.repeat_count);
            check_field("run_total", rsp_run_total, want.run_total);
            check_field("start_offset", rsp_start_offset, want.start_offset);
            check_field("run_length", rsp_run_length, want.run_length);
            check_field("fill_color", rsp_fill_color, want.fill_color);
            check_field("last_run", rsp_last_run, want.last_run);
            check_field("past_frame_end", rsp_past_frame_end, want.past_frame_end);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      req_valid       <= 1'b1;
      req_stream_byte <= b;
      do @(posedge clock); while (!req_ready);
      decode_stream_byte(b);
      bytes_sent++;
      gap = pick_gap(req_steady);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_header(input logic [7:0] hdr, input logic [7:0] rep,
                              input logic [15:0] count);
      send_byte(hdr);
      if (hdr[5])
         send_byte(rep);
      send_byte(count[7:0]);
      send_byte(count[15:8]);
   endtask

   task automatic wait_for_results;
      req_valid <= 1'b0;
      while (decoded_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input rld_pkg::csr_index_type idx, input logic [7:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         rld_pkg::CSR_BG_COLOR: col_off = val;
         rld_pkg::CSR_FG_COLOR: col_on  = val;
         default: ;
      endcase
      csr_writes++;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_frame;
      logic [15:0] count;
      int unsigned r;
      int unsigned rb;
      r = $urandom_range(0, 99);
      if (r < 5)
         count = 16'd0;
      else if (r < 75)
         count = 16'($urandom_range(1, 12));
      else if (r < 97)
         count = 16'($urandom_range(13, 60));
      else
         count = 16'($urandom_range(256, 300));
      send_header(8'($urandom), 8'($urandom), count);
      repeat (count) begin
         rb = $urandom_range(0, 99);
         if (rb < 12)
            send_byte(8'd0);
         else if (rb < 27)
            send_byte(rld_pkg::RUN_HOLD_LEN);
         else
            send_byte(8'($urandom));
      end
   endtask

   task automatic test_directed;
      // zero-run frame, start color on
      send_header(8'h00, 8'h00, 16'h0000);
      // repeat byte present, start color off; zero run, hold run, short run
      send_header(8'hA0, 8'hFF, 16'h0003);
      send_byte(8'h00);
      send_byte(rld_pkg::RUN_HOLD_LEN);
      send_byte(8'h01);
      // unused header bits set
      send_header(8'h5F, 8'h00, 16'h0002);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_header(8'hFF, 8'hAA, 16'h0001);
      send_byte(8'h55);
      wait_for_results();
   endtask

   task automatic test_frame_overflow;
      // overshoot, then runs after the end
      send_header(8'h00, 8'h00, 16'd305);
      repeat (302) send_byte(rld_pkg::RUN_HOLD_LEN);
      send_byte(8'h10);
      send_byte(8'h00);
      send_byte(rld_pkg::RUN_HOLD_LEN);
      wait_for_results();
      // exact fill, then one pixel too many
      send_header(8'h80, 8'h00, 16'd303);
      repeat (301) send_byte(rld_pkg::RUN_HOLD_LEN);
      send_byte(8'd45);
      send_byte(8'h01);
      wait_for_results();
   endtask

   task automatic test_backpressure;
      long_holds_asked++;
      req_steady = 1'b1;
      send_header(8'h20, 8'h03, 16'd60);
      repeat (60) send_byte(8'($urandom));
      req_steady = 1'b0;
      wait_for_results();
   endtask

   task automatic test_random_frames(input logic [7:0] off_val, input logic [7:0] on_val,
                                     input bit steady, input int unsigned byte_goal);
      int unsigned start;
      write_csr(rld_pkg::CSR_BG_COLOR, off_val);
      write_csr(rld_pkg::CSR_FG_COLOR, on_val);
      start = bytes_sent;
      req_steady = steady;
      rsp_steady = steady;
      while (bytes_sent - start < byte_goal)
         random_frame();
      req_steady = 1'b0;
      rsp_steady = 1'b0;
      wait_for_results();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_frame_overflow();
      test_backpressure();
      test_random_frames(8'h00, 8'hFF, 1'b0, 230);
      test_random_frames(8'hFF, 8'h00, 1'b0, 230);
      test_random_frames(8'h5A, 8'h5A, 1'b1, 230);
      test_random_frames(8'($urandom), 8'($urandom), 1'b0, 230);
      test_random_frames(8'h01, 8'hFE, 1'b0, 230);
      $display("Sent %0d stream bytes; checked %0d header and %0d run results.",
               bytes_sent, headers_seen, runs_seen);
      $display("Covered frame overflow, long output stalls and %0d color writes.",
               csr_writes);
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("Timed out with %0d results still pending.", decoded_due.size());
      $display("CHECK FAILED");
      $finish;
   end

endmodule
